/* sv/cumulative_table_search_macros.svh */
// Assertion shorthands used by the RTL; all are clocked on clk and
// switched off while rst_n is low.
`ifndef CUMULATIVE_TABLE_SEARCH_MACROS_SVH
`define CUMULATIVE_TABLE_SEARCH_MACROS_SVH

// Same-cycle implication.
`define CTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cumulative_table_search: same-cycle check failed");

// Next-cycle implication.
`define CTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cumulative_table_search: next-cycle check failed");

`endif

/* sv/cts_pkg.sv */
`default_nettype none
package cts_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W     = 9;
  localparam int INDEX_W     = 8;
  localparam int DATA_W      = 32;
  // wide enough for the count, the load index and the depth itself
  localparam int EXT_W_A     = (COUNT_W > INDEX_W) ? COUNT_W : INDEX_W;
  localparam int EXT_W       = (EXT_W_A > ADDR_W + 1) ? EXT_W_A : ADDR_W + 1;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [DATA_W-1:0] NOT_FOUND_KEY = '1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t val_cur;
    word_t val_prev;
    word_t key;
  } rd_data_t;

endpackage
`default_nettype wire

/* sv/cumulative_table_search.sv */
// Load beat: accepted in idle without a state change, so in_ready stays high.
// Search beat: one probe per cycle; the last probe holds while the result is stalled.
// result registered after k probes, k = 1..ceil(log2(n+1)), at most 9 for 256 entries.
// A search holds in_ready low until its result is registered; an empty table answers without probing.
// Reset clears the control state and entry_count; table contents stay undefined
// until loaded, with no clearing pass.
`default_nettype none
module cumulative_table_search (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [cts_pkg::COUNT_W-1:0]   cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_operation,
  input  wire logic [cts_pkg::INDEX_W-1:0]   in_entry_index,
  input  wire logic [cts_pkg::DATA_W-1:0]    in_entry_value,
  input  wire logic signed [cts_pkg::DATA_W-1:0] in_entry_key,
  input  wire logic [cts_pkg::DATA_W-1:0]    in_query_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_found,
  output logic signed [cts_pkg::DATA_W-1:0]  out_result_key
);
  import cts_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [COUNT_W-1:0] count_r;
  addr_t              lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  word_t              query_r, query_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  word_t              out_key_r, out_key_nxt;

  logic               in_accept, out_free, hit_lo, hit_hi, wr_en;
  logic [EXT_W-1:0]   n_ext, idx_ext;
  addr_t              hi_init, lo_right, hi_left;
  rd_data_t           rd_data;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign n_ext   = (EXT_W'(count_r) > EXT_W'(TABLE_DEPTH)) ? EXT_W'(TABLE_DEPTH)
                                                           : EXT_W'(count_r);
  assign hi_init = addr_t'(n_ext - EXT_W'(1));
  assign idx_ext = EXT_W'(in_entry_index);
  assign wr_en   = in_accept && (in_operation == OP_LOAD) &&
                   (idx_ext < EXT_W'(TABLE_DEPTH));

  assign hit_lo   = (mid_r == addr_t'(0)) || (query_r > rd_data.val_prev);
  assign hit_hi   = (query_r <= rd_data.val_cur);
  assign lo_right = mid_r + addr_t'(1);
  assign hi_left  = mid_r - addr_t'(1);

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    query_nxt     = query_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_key_nxt   = out_key_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_operation == OP_SEARCH)) begin
          query_nxt = in_query_value;
          lo_nxt    = addr_t'(0);
          hi_nxt    = hi_init;
          mid_nxt   = hi_init >> 1;
          state_nxt = (n_ext == EXT_W'(0)) ? ST_EMPTY : ST_PROBE;
        end
      end
      ST_PROBE: begin
        priority if (hit_lo && hit_hi) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b1;
            out_key_nxt   = rd_data.key;
            state_nxt     = ST_IDLE;
          end
        end else if (!hit_hi) begin
          // go right
          if (mid_r == hi_r) begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_found_nxt = 1'b0;
              out_key_nxt   = NOT_FOUND_KEY;
              state_nxt     = ST_IDLE;
            end
          end else begin
            lo_nxt  = lo_right;
            mid_nxt = lo_right + ((hi_r - lo_right) >> 1);
          end
        end else begin
          // go left
          if (mid_r == lo_r) begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_found_nxt = 1'b0;
              out_key_nxt   = NOT_FOUND_KEY;
              state_nxt     = ST_IDLE;
            end
          end else begin
            hi_nxt  = hi_left;
            mid_nxt = lo_r + ((hi_left - lo_r) >> 1);
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_key_nxt   = NOT_FOUND_KEY;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    query_r     <= query_nxt;
    out_found_r <= out_found_nxt;
    out_key_r   <= out_key_nxt;
  end

  // read address follows the next midpoint so the data lines up with mid_r
  cts_table u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (addr_t'(idx_ext)),
    .wr_value (in_entry_value),
    .wr_key   (word_t'(in_entry_key)),
    .rd_addr  (mid_nxt),
    .rd_data  (rd_data)
  );

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_result_key = out_key_r;

`include "cumulative_table_search_macros.svh"

  `CTS_ASSERT_NOW(a_mid_in_range, state_r == ST_PROBE, (lo_r <= mid_r) && (mid_r <= hi_r))
  `CTS_ASSERT_NEXT(a_search_probes, in_accept && (in_operation == OP_SEARCH) && (n_ext != EXT_W'(0)), state_r == ST_PROBE)
  `CTS_ASSERT_NEXT(a_load_no_result, in_accept && (in_operation == OP_LOAD) && !out_valid_r, !out_valid_r)

endmodule
`default_nettype wire

/* sv/cts_table.sv */
`default_nettype none
module cts_table (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire cts_pkg::addr_t    wr_addr,
  input  wire cts_pkg::word_t    wr_value,
  input  wire cts_pkg::word_t    wr_key,
  input  wire cts_pkg::addr_t    rd_addr,
  output cts_pkg::rd_data_t      rd_data
);
  import cts_pkg::*;

  word_t    val_mem [TABLE_DEPTH];
  word_t    key_mem [TABLE_DEPTH];
  addr_t    prev_addr;
  rd_data_t rd_data_r;

  // wraps at entry zero; the caller masks the lower bound there
  assign prev_addr = rd_addr - addr_t'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      val_mem[wr_addr] <= wr_value;
      key_mem[wr_addr] <= wr_key;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r.val_cur  <= val_mem[rd_addr];
    rd_data_r.val_prev <= val_mem[prev_addr];
    rd_data_r.key      <= key_mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* tb/tb_cumulative_table_search.sv */
`default_nettype none
module tb_cumulative_table_search;
  import cts_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_OFF_LEN  = 300;
  localparam int PHASE_ITEMS   = 110;

  typedef struct packed {
    logic        found;
    logic [31:0] key;
  } lookup_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [COUNT_W-1:0]   cfg_wr_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_operation;
  logic [INDEX_W-1:0]   in_entry_index;
  logic [DATA_W-1:0]    in_entry_value;
  logic signed [DATA_W-1:0] in_entry_key;
  logic [DATA_W-1:0]    in_query_value;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_found;
  logic signed [DATA_W-1:0] out_result_key;

  // predicted block state
  logic [DATA_W-1:0]  cum_value [TABLE_DEPTH];
  logic [DATA_W-1:0]  key_value [TABLE_DEPTH];
  logic [COUNT_W-1:0] active_count;

  lookup_result_t expected_lookups[$];
  int  errors;
  int  stall_cycles;
  bit  idle_enable;
  int  hold_off_len;
  bit  holding;

  cumulative_table_search dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_entry_key   (in_entry_key),
    .in_query_value (in_query_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_result_key (out_result_key)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic lookup_result_t lookup_key(logic [DATA_W-1:0] q);
    int span, lo, hi, mid;
    bit above_prev;
    lookup_result_t r;
    span = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
    lo = 0;
    hi = span - 1;
    r.found = 1'b0;
    r.key = NOT_FOUND_KEY;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      above_prev = (mid == 0) ? 1'b1 : (q > cum_value[mid-1]);
      if (above_prev && q <= cum_value[mid]) begin
        r.found = 1'b1;
        r.key = key_value[mid];
        return r;
      end
      if (q > cum_value[mid]) lo = mid + 1;
      else hi = mid - 1;
    end
    return r;
  endfunction

  // mostly land on or next to a boundary of the active entries
  function automatic logic [DATA_W-1:0] pick_query();
    int span, j;
    span = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
    j = $urandom_range(0, (span == 0) ? TABLE_DEPTH - 1 : span - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return cum_value[j] + DATA_W'($urandom_range(0, 2)) - 1;
      6, 7:             return $urandom();
      8:                return '0;
      default:          return '1;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] got_v);
    $display("MISMATCH %s: expected %h got %h at %0t", what, exp_v, got_v, $time);
    errors++;
  endtask

  task automatic send_item(logic op, logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] val,
                           logic [DATA_W-1:0] key, logic [DATA_W-1:0] q);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_entry_index <= idx;
    in_entry_value <= val;
    in_entry_key   <= key;
    in_query_value <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_LOAD) begin
      if (idx < TABLE_DEPTH) begin
        cum_value[idx] = val;
        key_value[idx] = key;
      end
    end else begin
      expected_lookups.push_back(lookup_key(q));
    end
  endtask

  task automatic load_entry(logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] val, logic [DATA_W-1:0] key);
    send_item(OP_LOAD, idx, val, key, $urandom());
  endtask

  task automatic search(logic [DATA_W-1:0] q);
    send_item(OP_SEARCH, INDEX_W'($urandom()), $urandom(), $urandom(), q);
  endtask

  // drop valid, hold until every result is back, then let a load finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_lookups.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [COUNT_W-1:0] n);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    active_count = n;
  endtask

  // sorted cumulative values, loaded in a scrambled index order
  task automatic fill_table(int unsigned max_step);
    logic [DATA_W-1:0] vals [TABLE_DEPTH];
    logic [DATA_W-1:0] acc;
    int offset, idx;
    acc = $urandom_range(0, 255);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      vals[i] = acc;
      acc += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, max_step);
    end
    vals[TABLE_DEPTH-1] = '1;
    offset = $urandom_range(0, TABLE_DEPTH - 1);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      idx = (i * 167 + offset) % TABLE_DEPTH;
      load_entry(INDEX_W'(idx), vals[idx], $urandom());
    end
  endtask

  task automatic test_empty_table();
    search('0);
    search('1);
  endtask

  task automatic test_small_table();
    load_entry(8'd0, 32'h0000_0010, 32'h8000_0000);
    load_entry(8'd1, 32'h4000_0000, 32'h7FFF_FFFF);
    load_entry(8'd2, 32'h4000_0000, 32'h0000_0000);
    load_entry(8'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_count(9'd4);
    search(32'h0000_0000);
    search(32'h0000_0010);
    search(32'h0000_0011);
    search(32'h4000_0000);
    search(32'h4000_0001);
    search(32'hFFFF_FFFF);
    write_count(9'd3);
    search(32'hFFFF_FFFF);
    write_count(9'd1);
    search(32'h0000_0010);
    search(32'h0000_0011);
  endtask

  task automatic test_unsorted_table();
    load_entry(8'd1, 32'h0000_0005, 32'h1234_5678);
    write_count(9'd4);
    search(32'h0000_0005);
    search(32'h0000_0020);
    search(32'h4000_0000);
  endtask

  task automatic test_count_above_depth();
    write_count(9'd256);
    repeat (4) search(pick_query());
    write_count(9'd257);
    repeat (4) search(pick_query());
    write_count(9'd511);
    repeat (4) search(pick_query());
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_off_len = HOLD_OFF_LEN;
    wait (holding);
    repeat (12) search(pick_query());
  endtask

  task automatic test_drain_pause();
    repeat (10) search(pick_query());
    wait_idle();
    repeat (10) search(pick_query());
  endtask

  task automatic test_random_phases();
    logic [COUNT_W-1:0] phase_count [10];
    logic [DATA_W-1:0] lo_v, hi_v, tmp;
    int idx;
    phase_count = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd2, 9'd257,
                    COUNT_W'($urandom_range(0, 511)), 9'd3,
                    COUNT_W'($urandom_range(0, 511)), 9'd255};
    for (int p = 0; p < 10; p++) begin
      if (p == 5) fill_table(2 ** 20);
      if (p >= 8) idle_enable = 1'b0;
      write_count(phase_count[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 9) < 7) begin
          search(pick_query());
        end else begin
          idx = $urandom_range(0, TABLE_DEPTH - 1);
          if ($urandom_range(0, 4) != 0) begin
            // keep the neighbourhood in order
            lo_v = (idx == 0) ? '0 : cum_value[idx-1];
            hi_v = (idx == TABLE_DEPTH - 1) ? '1 : cum_value[idx+1];
            if (lo_v > hi_v) begin
              tmp = lo_v;
              lo_v = hi_v;
              hi_v = tmp;
            end
            load_entry(INDEX_W'(idx), $urandom_range(hi_v, lo_v), $urandom());
          end else begin
            load_entry(INDEX_W'(idx), $urandom(), $urandom());
          end
        end
      end
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_len > 0) begin
        holding = 1'b1;
        out_ready <= 1'b0;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
        holding = 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_lookups.size() == 0) begin
        report_mismatch("unexpected result", '0, out_result_key);
      end else begin
        exp_r = expected_lookups.pop_front();
        if (out_found !== exp_r.found) report_mismatch("found", exp_r.found, out_found);
        if (out_result_key !== exp_r.key) report_mismatch("result_key", exp_r.key, out_result_key);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("cumulative_table_search test failed");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_operation   = OP_LOAD;
    in_entry_index = '0;
    in_entry_value = '0;
    in_entry_key   = '0;
    in_query_value = '0;
    out_ready      = 1'b0;
    errors         = 0;
    stall_cycles   = 0;
    idle_enable    = 1'b1;
    hold_off_len   = 0;
    holding        = 1'b0;
    active_count   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_small_table();
    test_unsorted_table();
    fill_table(2 ** 24 - 1);
    test_count_above_depth();
    test_backpressure();
    test_drain_pause();
    test_random_phases();
    wait_idle();

    if (errors == 0) begin
      $display("cumulative_table_search test passed");
    end else begin
      $display("cumulative_table_search test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
